>>> hdl/hvr_pkg.sv
// Shared types and constants for the voxel ray walker.
// No dependencies; imported by every module of the block.
`default_nettype none
package hvr_pkg;
    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_STEP   = 2'd1;
    localparam logic [1:0] KIND_UPDATE = 2'd2;
    localparam logic [1:0] KIND_NOP    = 2'd3;

    localparam logic [30:0] TIME_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic [30:0]        t_start;
        logic [30:0]        t_end;
        logic [3:0]         level;   // already clamped
    } item_t;

    typedef struct packed {
        logic valid;
        logic ready;
    } hs_t;
endpackage
`default_nettype wire

>>> hdl/hierarchical_voxel_ray_dda.sv
// Top level of the voxel ray walker: config register, front end, back end.
// Depends on hvr_pkg, hvr_front, hvr_back.
//
// Usage: send transactions on s_* (kind 0 start ray, 1 step, 2 change block
// level, 3 no-op). Each transaction returns exactly one result on m_*, in order.
// cfg_* writes near_zero_limit; write it only while the block is idle.
// A step passes the skid register and the queue, and the back end answers it
// as it pops it; a no-op or an unchanged update goes through the emit state.
// Steps sustain one per cycle while m_ready is high. A start, or an update that
// changes the level, runs the axis setup sequencer: per axis one multiply, one
// position step and two bit-serial divisions (crossing time, then step time),
// after which the result is emitted; disabled axes skip the divisions.
// Reset (aresetn low, synchronous) clears walker state and the result
// valid; near_zero_limit returns to 1. A stalled m_ready holds the result;
// the two-entry queue and input skid register keep accepting until full.
`default_nettype none
module hierarchical_voxel_ray_dda
    import hvr_pkg::*;
#(
    parameter int MAX_LEVEL_LOG2 = 12,
    parameter int COORD_BITS     = 32
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_kind,
    input  wire logic signed [31:0] s_eye_x,
    input  wire logic signed [31:0] s_eye_y,
    input  wire logic signed [31:0] s_eye_z,
    input  wire logic signed [31:0] s_dir_x,
    input  wire logic signed [31:0] s_dir_y,
    input  wire logic signed [31:0] s_dir_z,
    input  wire logic [30:0]        s_t_start,
    input  wire logic [30:0]        s_t_end,
    input  wire logic [3:0]         s_level_log2,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_voxel_x,
    output logic signed [15:0]      m_voxel_y,
    output logic signed [15:0]      m_voxel_z,
    output logic signed [31:0]      m_t_now,
    output logic                    m_still_inside,
    output logic                    m_size_changed
);
    logic [15:0] nzl_reg;
    logic        pop, not_empty;
    item_t       head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) nzl_reg <= 16'd1;
        else if (cfg_valid) nzl_reg <= cfg_data;
    end

    hvr_front #(.MAX_LEVEL_LOG2(MAX_LEVEL_LOG2)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_eye_x(s_eye_x), .s_eye_y(s_eye_y), .s_eye_z(s_eye_z),
        .s_dir_x(s_dir_x), .s_dir_y(s_dir_y), .s_dir_z(s_dir_z),
        .s_t_start(s_t_start), .s_t_end(s_t_end), .s_level_log2(s_level_log2),
        .pop(pop), .not_empty(not_empty), .head(head)
    );

    hvr_back #(.MAX_LEVEL_LOG2(MAX_LEVEL_LOG2), .COORD_BITS(COORD_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .near_zero_limit(nzl_reg),
        .q_not_empty(not_empty), .q_head(head), .q_pop(pop),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_voxel_x(m_voxel_x), .m_voxel_y(m_voxel_y), .m_voxel_z(m_voxel_z),
        .m_t_now(m_t_now), .m_still_inside(m_still_inside),
        .m_size_changed(m_size_changed)
    );
endmodule
`default_nettype wire

>>> hdl/hvr_fifo.sv
// Two-entry queue of decoded transactions between front and back.
// Depends on hvr_pkg.
`default_nettype none
module hvr_fifo
    import hvr_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire hs_t   push_hs,   // valid from writer, ready fed back from full
    input  wire item_t push_item,
    output logic       full,
    input  wire logic  pop,
    output logic       not_empty,
    output item_t      head
);
    item_t      mem_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign push      = push_hs.valid && push_hs.ready;
    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wr_reg <= !wr_reg;
            if (pop)  rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) mem_reg[wr_reg] <= push_item;
    end
endmodule
`default_nettype wire

>>> hdl/hvr_front.sv
// Front end: input skid register, level clamp, hand-off to the queue.
// Depends on hvr_pkg and hvr_fifo.
`default_nettype none
module hvr_front
    import hvr_pkg::*;
#(
    parameter int MAX_LEVEL_LOG2 = 12
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_kind,
    input  wire logic signed [31:0] s_eye_x,
    input  wire logic signed [31:0] s_eye_y,
    input  wire logic signed [31:0] s_eye_z,
    input  wire logic signed [31:0] s_dir_x,
    input  wire logic signed [31:0] s_dir_y,
    input  wire logic signed [31:0] s_dir_z,
    input  wire logic [30:0]        s_t_start,
    input  wire logic [30:0]        s_t_end,
    input  wire logic [3:0]         s_level_log2,
    input  wire logic               pop,
    output logic                    not_empty,
    output item_t                   head
);
    localparam logic [3:0] LMAX = 4'(MAX_LEVEL_LOG2);

    item_t hold_reg;
    logic  hold_vld_reg;
    logic  full, xfer;
    hs_t   push_hs;

    assign push_hs.valid = hold_vld_reg;
    assign push_hs.ready = !full;
    assign xfer    = hold_vld_reg && !full;
    assign s_ready = !hold_vld_reg || xfer;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_vld_reg <= 1'b0;
        end else if (s_ready) begin
            hold_vld_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            hold_reg.kind    <= s_kind;
            hold_reg.eye_x   <= s_eye_x;
            hold_reg.eye_y   <= s_eye_y;
            hold_reg.eye_z   <= s_eye_z;
            hold_reg.dir_x   <= s_dir_x;
            hold_reg.dir_y   <= s_dir_y;
            hold_reg.dir_z   <= s_dir_z;
            hold_reg.t_start <= s_t_start;
            hold_reg.t_end   <= s_t_end;
            hold_reg.level   <= (s_level_log2 > LMAX) ? LMAX : s_level_log2;
        end
    end

    hvr_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_hs   (push_hs),
        .push_item (hold_reg),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );
endmodule
`default_nettype wire

>>> hdl/hvr_back.sv
// Back end: walker state, step logic, axis setup sequencer with a shared
// multiplier and bit-serial divider, output register. Depends on hvr_pkg.
`default_nettype none
module hvr_back
    import hvr_pkg::*;
#(
    parameter int MAX_LEVEL_LOG2 = 12,
    parameter int COORD_BITS     = 32
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [15:0]        near_zero_limit,
    input  wire logic               q_not_empty,
    input  wire item_t              q_head,
    output logic                    q_pop,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_voxel_x,
    output logic signed [15:0]      m_voxel_y,
    output logic signed [15:0]      m_voxel_z,
    output logic signed [31:0]      m_t_now,
    output logic                    m_still_inside,
    output logic                    m_size_changed
);
    localparam int DW = 33 + MAX_LEVEL_LOG2;   // holds 2^level << 32
    localparam int CW = $clog2(DW + 1);
    localparam int CB = COORD_BITS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_POS  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic signed [31:0] eye_reg [3];
    logic signed [31:0] dir_reg [3];
    logic [CB-1:0]      cell_reg [3];
    logic [30:0]        cross_reg [3];
    logic [30:0]        tstep_reg [3];
    logic               sign_reg [3];
    logic [30:0]        tnow_reg, tlim_reg;
    logic [3:0]         lvl_reg;
    logic [2:0]         st_reg;
    logic [1:0]         ax_reg;
    logic [62:0]        prod_reg;
    logic [31:0]        rem_reg;
    logic [DW-1:0]      quo_reg, dvd_reg;
    logic [CW-1:0]      cnt_reg;
    logic               phase_reg, chg_reg;

    logic               out_free;
    logic               emit;
    logic               neg;
    logic [31:0]        mag;
    logic [CB-1:0]      dim_c;
    logic [DW-1:0]      dim_w, off, gap;
    logic [63:0]        pos;
    logic               disabled;
    logic [32:0]        rs;
    logic               qbit;
    logic [31:0]        rem_n;
    logic [DW-1:0]      quo_n;
    logic [DW:0]        tsum;
    logic [30:0]        cross_sat, step_sat;
    logic [1:0]         sel;
    logic [31:0]        csum;
    logic [CB-1:0]      cell_st [3];
    logic [30:0]        tnow_st;

    assign out_free = !m_valid || m_ready;

    // current axis operands
    assign neg   = dir_reg[ax_reg][31];
    assign mag   = neg ? (32'd0 - dir_reg[ax_reg]) : dir_reg[ax_reg];
    assign dim_c = CB'(1) << lvl_reg;
    assign dim_w = DW'(1) << (6'd32 + {2'b00, lvl_reg});
    assign pos   = {{16{eye_reg[ax_reg][31]}}, eye_reg[ax_reg], 16'd0}
                 + (neg ? (64'd0 - {1'b0, prod_reg}) : {1'b0, prod_reg});
    assign off   = pos[DW-1:0] & (dim_w - DW'(1));
    assign gap   = neg ? off : (dim_w - off);
    assign disabled = (mag == 32'd0) || (mag < {16'd0, near_zero_limit});

    // restoring divider step
    assign rs    = {rem_reg, dvd_reg[DW-1]};
    assign qbit  = (rs >= {1'b0, mag});
    assign rem_n = qbit ? 32'(rs - {1'b0, mag}) : rs[31:0];
    assign quo_n = {quo_reg[DW-2:0], qbit};
    assign tsum  = {1'b0, quo_n} + (DW+1)'(tnow_reg);
    assign cross_sat = (|tsum[DW:31]) ? TIME_MAX : tsum[30:0];
    assign step_sat  = (|quo_n[DW-1:31]) ? TIME_MAX : quo_n[30:0];

    // step: earliest crossing, ties go to the later axis
    always_comb begin
        if (cross_reg[0] < cross_reg[1] && cross_reg[0] < cross_reg[2]) sel = 2'd0;
        else if (cross_reg[1] < cross_reg[2])                            sel = 2'd1;
        else                                                             sel = 2'd2;
        csum    = {1'b0, cross_reg[sel]} + {1'b0, tstep_reg[sel]};
        tnow_st = cross_reg[sel];
        for (int a = 0; a < 3; a++) begin
            cell_st[a] = cell_reg[a];
            if (sel == 2'(a) && tstep_reg[a] != 31'd0)
                cell_st[a] = sign_reg[a] ? (cell_reg[a] - dim_c) : (cell_reg[a] + dim_c);
        end
    end

    assign q_pop = (st_reg == ST_IDLE) && q_not_empty && out_free;
    assign emit  = (q_pop && q_head.kind == KIND_STEP) || (st_reg == ST_EMIT && out_free);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= ST_IDLE;
            m_valid  <= 1'b0;
            tnow_reg <= 31'd0;
            tlim_reg <= 31'd0;
            lvl_reg  <= 4'd0;
            for (int a = 0; a < 3; a++) begin
                cell_reg[a]  <= '0;
                cross_reg[a] <= TIME_MAX;
                tstep_reg[a] <= 31'd0;
                sign_reg[a]  <= 1'b0;
            end
        end else begin
            if (emit)         m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
            unique case (st_reg)
                ST_IDLE: begin
                    if (q_pop) begin
                        ax_reg  <= 2'd0;
                        chg_reg <= 1'b0;
                        case (q_head.kind)
                            KIND_START: begin
                                eye_reg[0] <= q_head.eye_x;
                                eye_reg[1] <= q_head.eye_y;
                                eye_reg[2] <= q_head.eye_z;
                                dir_reg[0] <= q_head.dir_x;
                                dir_reg[1] <= q_head.dir_y;
                                dir_reg[2] <= q_head.dir_z;
                                tnow_reg   <= q_head.t_start;
                                tlim_reg   <= q_head.t_end;
                                lvl_reg    <= q_head.level;
                                st_reg     <= ST_MUL;
                            end
                            KIND_STEP: begin
                                tnow_reg <= tnow_st;
                                cross_reg[sel] <= csum[31] ? TIME_MAX : csum[30:0];
                                for (int a = 0; a < 3; a++) cell_reg[a] <= cell_st[a];
                                m_voxel_x      <= cell_st[0][15:0];
                                m_voxel_y      <= cell_st[1][15:0];
                                m_voxel_z      <= cell_st[2][15:0];
                                m_t_now        <= {1'b0, tnow_st};
                                m_still_inside <= (tnow_st <= tlim_reg);
                                m_size_changed <= 1'b0;
                            end
                            KIND_UPDATE: begin
                                if (q_head.level != lvl_reg) begin
                                    lvl_reg <= q_head.level;
                                    chg_reg <= 1'b1;
                                    st_reg  <= ST_MUL;
                                end else begin
                                    st_reg <= ST_EMIT;
                                end
                            end
                            default: st_reg <= ST_EMIT;
                        endcase
                    end
                end
                ST_MUL: begin
                    prod_reg <= {32'd0, tnow_reg} * {31'd0, mag};
                    st_reg   <= ST_POS;
                end
                ST_POS: begin
                    cell_reg[ax_reg] <= CB'({{32{pos[63]}}, pos[63:32]})
                                        & ~(dim_c - CB'(1));
                    if (disabled) begin
                        cross_reg[ax_reg] <= TIME_MAX;
                        tstep_reg[ax_reg] <= 31'd0;
                        sign_reg[ax_reg]  <= 1'b0;
                        ax_reg <= ax_reg + 2'd1;
                        st_reg <= (ax_reg == 2'd2) ? ST_EMIT : ST_MUL;
                    end else begin
                        sign_reg[ax_reg] <= neg;
                        dvd_reg   <= gap;
                        rem_reg   <= 32'd0;
                        cnt_reg   <= CW'(DW);
                        phase_reg <= 1'b0;
                        st_reg    <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    rem_reg <= rem_n;
                    quo_reg <= quo_n;
                    dvd_reg <= {dvd_reg[DW-2:0], 1'b0};
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1)) begin
                        if (!phase_reg) begin
                            cross_reg[ax_reg] <= cross_sat;
                            dvd_reg   <= dim_w;
                            rem_reg   <= 32'd0;
                            cnt_reg   <= CW'(DW);
                            phase_reg <= 1'b1;
                        end else begin
                            tstep_reg[ax_reg] <= step_sat;
                            ax_reg <= ax_reg + 2'd1;
                            st_reg <= (ax_reg == 2'd2) ? ST_EMIT : ST_MUL;
                        end
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_voxel_x      <= cell_reg[0][15:0];
                        m_voxel_y      <= cell_reg[1][15:0];
                        m_voxel_z      <= cell_reg[2][15:0];
                        m_t_now        <= {1'b0, tnow_reg};
                        m_still_inside <= (tnow_reg <= tlim_reg);
                        m_size_changed <= chg_reg;
                        st_reg         <= ST_IDLE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> hdl/hvr_checker.sv
// Port-level checks for the voxel ray walker, bound to the top level.
// Depends on hierarchical_voxel_ray_dda port names only.
`default_nettype none
module hvr_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [31:0] m_t_now,
    input wire logic               m_size_changed
);
    // result held while receiver stalls
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_t_now)
                                && $stable(m_size_changed))
        else $error("result changed while stalled");

    // input transaction stays offered until taken
    a_s_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("input dropped before acceptance");

    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // times never go negative
    a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !m_t_now[31])
        else $error("negative time reported");

    // no result may rise straight out of reset
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(!aresetn))
        else $error("result right out of reset");
endmodule

bind hierarchical_voxel_ray_dda hvr_checker u_hvr_checker (.*);
`default_nettype wire
